@@ rtl/core/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the subband channel correlator modules.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int PORT_W          = 16;
  localparam int PROD_W          = 2 * PORT_W;
  localparam int ACC_W           = 40;
  localparam int CORR_W          = 36;
  localparam int WIDE_W          = 39;
  localparam int RES_W           = 7;
  localparam int CNT_W           = 5;
  localparam int IDX_W           = 4;
  localparam int CFG_IDX_W       = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGULAR_RES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_RES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SB_COUNT    = 2'd2;

  localparam logic [RES_W-1:0] REGULAR_RES_RST = 7'd48;
  localparam logic [RES_W-1:0] LAST_RES_RST    = 7'd12;
  localparam logic [CNT_W-1:0] SB_COUNT_RST    = 5'd7;

  localparam logic [IDX_W-1:0] SB_IDX_MAX = 4'd15;

  localparam logic signed [ACC_W-1:0] CORR_MAX = 40'sd34359738367;
  localparam logic signed [ACC_W-1:0] CORR_MIN = -40'sd34359738368;
  localparam logic signed [ACC_W-1:0] WIDE_MAX = 40'sd274877906943;
  localparam logic signed [ACC_W-1:0] WIDE_MIN = -40'sd274877906944;

  typedef struct packed {
    logic [RES_W-1:0] regular_res;
    logic [RES_W-1:0] last_res;
    logic [CNT_W-1:0] sb_count;
  } cfg_t;

  // One classified element as it travels from the front end to the back end.
  typedef struct packed {
    logic                     pass_start;
    logic                     complete;
    logic                     is_last;
    logic [IDX_W-1:0]         sb_idx;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] p_ri;
  } elem_t;

endpackage

@@ rtl/core/subband_channel_correlator.sv @@
// ----------------------------------------------------------------------------
// subband_channel_correlator
// Correlates two antenna channel estimates per subband and over the band.
// ----------------------------------------------------------------------------
// Each input beat carries one resource element: the complex estimates of two
// antennas and a pass-start flag that clears all running state first. The
// block sums ch0 * conj(ch1) over each subband; when a subband completes it
// sends one output beat with the sums shifted right by two and saturated to
// 36 bits, the saturated wideband sums and a flag for the final subband.
// Elements that do not complete a subband produce no output beat.
// One element is taken every cycle while in_stall is low. A result for
// the element that completes its subband passes the two-entry queue
// behind the multipliers and the accumulator stage register, after which
// the scaling and wideband adder loads the output register.
// A receiver stall holds the output beat. The accumulator keeps taking
// elements until a second completed subband waits behind the output
// register; the queue then fills with two elements and in_stall rises.
// Reset (synchronous, rst_n low) clears sums and counters and loads default
// subband sizes. Users write configuration via cfg_we while idle; unenforced.
// ----------------------------------------------------------------------------
module subband_channel_correlator #(
  parameter int SAMPLE_BITS = scc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scc_pkg::RES_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch0_re,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch0_im,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch1_re,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch1_im,
  input  logic                                in_pass_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [scc_pkg::IDX_W-1:0]           out_subband_index,
  output logic signed [scc_pkg::CORR_W-1:0]   out_corr_re,
  output logic signed [scc_pkg::CORR_W-1:0]   out_corr_im,
  output logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_re,
  output logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_im,
  output logic                                out_last
);

  scc_pkg::cfg_t  cfg_r;
  scc_pkg::elem_t push_data, pop_data;
  logic           q_push, q_pop, q_full, q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.regular_res <= scc_pkg::REGULAR_RES_RST;
      cfg_r.last_res    <= scc_pkg::LAST_RES_RST;
      cfg_r.sb_count    <= scc_pkg::SB_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::CFG_REGULAR_RES: cfg_r.regular_res <= cfg_wdata;
        scc_pkg::CFG_LAST_RES:    cfg_r.last_res    <= cfg_wdata;
        scc_pkg::CFG_SB_COUNT:    cfg_r.sb_count    <= cfg_wdata[scc_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;

  scc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ch0_re    (in_ch0_re),
    .in_ch0_im    (in_ch0_im),
    .in_ch1_re    (in_ch1_re),
    .in_ch1_im    (in_ch1_im),
    .in_pass_start(in_pass_start),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  scc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .pop_data (pop_data)
  );

  scc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_subband_index(out_subband_index),
    .out_corr_re      (out_corr_re),
    .out_corr_im      (out_corr_im),
    .out_wideband_re  (out_wideband_re),
    .out_wideband_im  (out_wideband_im),
    .out_last         (out_last)
  );

endmodule

@@ rtl/core/scc_front.sv @@
// ----------------------------------------------------------------------------
// scc_front
// Accepts elements, tracks subband position and forms the four products.
// ----------------------------------------------------------------------------
module scc_front #(
  parameter int SAMPLE_BITS = scc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  scc_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  logic signed [scc_pkg::PORT_W-1:0] in_ch0_re,
  input  logic signed [scc_pkg::PORT_W-1:0] in_ch0_im,
  input  logic signed [scc_pkg::PORT_W-1:0] in_ch1_re,
  input  logic signed [scc_pkg::PORT_W-1:0] in_ch1_im,
  input  logic                             in_pass_start,
  input  logic                             q_full,
  output logic                             q_push,
  output scc_pkg::elem_t                   q_data
);

  logic [scc_pkg::RES_W-1:0]  count_r, count_nxt;
  logic [scc_pkg::IDX_W-1:0]  sb_r, sb_nxt;
  logic [scc_pkg::RES_W-1:0]  cnt_cur, len;
  logic [scc_pkg::IDX_W-1:0]  sb_cur;
  logic                       is_last, complete;
  logic signed [scc_pkg::PORT_W-1:0] a_re, a_im, b_re, b_im;

  assign q_push = in_valid && !q_full;

  // Only the low SAMPLE_BITS bits of each part carry the sample.
  assign a_re = scc_pkg::PORT_W'(signed'(in_ch0_re[SAMPLE_BITS-1:0]));
  assign a_im = scc_pkg::PORT_W'(signed'(in_ch0_im[SAMPLE_BITS-1:0]));
  assign b_re = scc_pkg::PORT_W'(signed'(in_ch1_re[SAMPLE_BITS-1:0]));
  assign b_im = scc_pkg::PORT_W'(signed'(in_ch1_im[SAMPLE_BITS-1:0]));

  always_comb begin
    cnt_cur  = in_pass_start ? '0 : count_r;
    sb_cur   = in_pass_start ? '0 : sb_r;
    is_last  = (({1'b0, sb_cur} + 5'd1) >= cfg.sb_count) || (sb_cur == scc_pkg::SB_IDX_MAX);
    len      = is_last ? cfg.last_res : cfg.regular_res;
    complete = (({1'b0, cnt_cur} + 8'd1) >= {1'b0, len});
    if (complete) begin
      count_nxt = '0;
      sb_nxt    = is_last ? '0 : sb_cur + 4'd1;
    end else begin
      count_nxt = cnt_cur + 7'd1;
      sb_nxt    = sb_cur;
    end
  end

  always_comb begin
    q_data.pass_start = in_pass_start;
    q_data.complete   = complete;
    q_data.is_last    = is_last;
    q_data.sb_idx     = sb_cur;
    q_data.p_rr       = a_re * b_re;
    q_data.p_ii       = a_im * b_im;
    q_data.p_ir       = a_im * b_re;
    q_data.p_ri       = a_re * b_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sb_r    <= '0;
    end else if (q_push) begin
      count_r <= count_nxt;
      sb_r    <= sb_nxt;
    end
  end

endmodule

@@ rtl/core/scc_fifo.sv @@
// ----------------------------------------------------------------------------
// scc_fifo
// Two-entry queue that decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
module scc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scc_pkg::elem_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output scc_pkg::elem_t pop_data
);

  scc_pkg::elem_t mem_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/scc_back.sv @@
// ----------------------------------------------------------------------------
// scc_back
// Accumulates subband sums, then scales, saturates and folds them into the
// wideband sums in a second stage that feeds the output register.
// ----------------------------------------------------------------------------
module scc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  scc_pkg::elem_t                      q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [scc_pkg::IDX_W-1:0]           out_subband_index,
  output logic signed [scc_pkg::CORR_W-1:0]   out_corr_re,
  output logic signed [scc_pkg::CORR_W-1:0]   out_corr_im,
  output logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_re,
  output logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_im,
  output logic                                out_last
);

  localparam int AW = scc_pkg::ACC_W;

  logic signed [AW-1:0] acc_re_r, acc_im_r;
  logic                 clr_pend_r;
  logic                 mid_v_r, mid_clr_r, mid_last_r;
  logic [scc_pkg::IDX_W-1:0] mid_idx_r;
  logic signed [AW-1:0] mid_re_r, mid_im_r;
  logic signed [scc_pkg::WIDE_W-1:0] wide_re_r, wide_im_r;
  logic                 out_valid_r;

  logic                 out_free, mid_go;
  logic signed [scc_pkg::PROD_W:0] pair_re, pair_im;
  logic signed [AW-1:0] base_re, base_im, sum_re, sum_im;
  logic signed [AW-1:0] shr_re, shr_im, c_re, c_im;
  logic signed [AW-1:0] wsum_re, wsum_im, wsat_re, wsat_im;

  function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] v,
                                               input logic signed [AW-1:0] lo,
                                               input logic signed [AW-1:0] hi);
    logic signed [AW-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign mid_go    = mid_v_r && out_free;
  assign q_pop     = q_valid && (!mid_v_r || out_free);
  assign out_valid = out_valid_r;

  // Accumulate stage.
  always_comb begin
    pair_re = (scc_pkg::PROD_W+1)'(q_data.p_rr) + (scc_pkg::PROD_W+1)'(q_data.p_ii);
    pair_im = (scc_pkg::PROD_W+1)'(q_data.p_ir) - (scc_pkg::PROD_W+1)'(q_data.p_ri);
    base_re = q_data.pass_start ? '0 : acc_re_r;
    base_im = q_data.pass_start ? '0 : acc_im_r;
    sum_re  = base_re + AW'(pair_re);
    sum_im  = base_im + AW'(pair_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r   <= '0;
      acc_im_r   <= '0;
      clr_pend_r <= 1'b0;
      mid_v_r    <= 1'b0;
    end else begin
      if (q_pop) begin
        if (q_data.complete) begin
          acc_re_r   <= '0;
          acc_im_r   <= '0;
          clr_pend_r <= 1'b0;
          mid_v_r    <= 1'b1;
        end else begin
          acc_re_r   <= sum_re;
          acc_im_r   <= sum_im;
          clr_pend_r <= clr_pend_r | q_data.pass_start;
          if (mid_go) begin
            mid_v_r <= 1'b0;
          end
        end
      end else if (mid_go) begin
        mid_v_r <= 1'b0;
      end
    end
  end

  // A pass start clears the wideband sums; the clear rides with the next
  // completed subband so that it lands in order in the second stage.
  always_ff @(posedge clk) begin
    if (q_pop && q_data.complete) begin
      mid_re_r   <= sum_re;
      mid_im_r   <= sum_im;
      mid_idx_r  <= q_data.sb_idx;
      mid_last_r <= q_data.is_last;
      mid_clr_r  <= clr_pend_r | q_data.pass_start;
    end
  end

  // Scale and wideband stage.
  always_comb begin
    shr_re  = mid_re_r >>> 2;
    shr_im  = mid_im_r >>> 2;
    c_re    = sat(shr_re, scc_pkg::CORR_MIN, scc_pkg::CORR_MAX);
    c_im    = sat(shr_im, scc_pkg::CORR_MIN, scc_pkg::CORR_MAX);
    wsum_re = (mid_clr_r ? '0 : AW'(wide_re_r)) + c_re;
    wsum_im = (mid_clr_r ? '0 : AW'(wide_im_r)) + c_im;
    wsat_re = sat(wsum_re, scc_pkg::WIDE_MIN, scc_pkg::WIDE_MAX);
    wsat_im = sat(wsum_im, scc_pkg::WIDE_MIN, scc_pkg::WIDE_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wide_re_r   <= '0;
      wide_im_r   <= '0;
    end else if (mid_go) begin
      out_valid_r <= 1'b1;
      wide_re_r   <= wsat_re[scc_pkg::WIDE_W-1:0];
      wide_im_r   <= wsat_im[scc_pkg::WIDE_W-1:0];
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_go) begin
      out_subband_index <= mid_idx_r;
      out_corr_re       <= c_re[scc_pkg::CORR_W-1:0];
      out_corr_im       <= c_im[scc_pkg::CORR_W-1:0];
      out_wideband_re   <= wsat_re[scc_pkg::WIDE_W-1:0];
      out_wideband_im   <= wsat_im[scc_pkg::WIDE_W-1:0];
      out_last          <= mid_last_r;
    end
  end

endmodule

@@ bench/scc_result_checker.sv @@
// ----------------------------------------------------------------------------
// scc_result_checker
// Predicts and checks the subband results of the channel correlator.
// ----------------------------------------------------------------------------
// Watches the configuration port and both channels. Every element taken on
// the input channel is run through a cycle-free model of the correlator.
// That model keeps its own copy of the registers, the subband and wideband
// sums and the counters. Each subband it completes is queued, and every
// output beat is compared field by field with the oldest queued subband.
// The failure count and the number of subbands still due go to the top.
// ----------------------------------------------------------------------------
module scc_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scc_pkg::RES_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch0_re,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch0_im,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch1_re,
  input  logic signed [scc_pkg::PORT_W-1:0]   in_ch1_im,
  input  logic                                in_pass_start,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [scc_pkg::IDX_W-1:0]           out_subband_index,
  input  logic signed [scc_pkg::CORR_W-1:0]   out_corr_re,
  input  logic signed [scc_pkg::CORR_W-1:0]   out_corr_im,
  input  logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_re,
  input  logic signed [scc_pkg::WIDE_W-1:0]   out_wideband_im,
  input  logic                                out_last,
  output int                                  mismatch_count,
  output int                                  subbands_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [scc_pkg::IDX_W-1:0]         index;
    logic signed [scc_pkg::CORR_W-1:0] corr_re;
    logic signed [scc_pkg::CORR_W-1:0] corr_im;
    logic signed [scc_pkg::WIDE_W-1:0] wide_re;
    logic signed [scc_pkg::WIDE_W-1:0] wide_im;
    logic                              closing;
  } subband_sums_t;

  logic [scc_pkg::RES_W-1:0] regular_len;
  logic [scc_pkg::RES_W-1:0] last_len;
  logic [scc_pkg::CNT_W-1:0] band_count;

  longint                    band_re;
  longint                    band_im;
  longint                    wide_re;
  longint                    wide_im;
  int unsigned               elem_count;
  logic [scc_pkg::IDX_W-1:0] band_idx;
  int                        errors;

  subband_sums_t    due_subbands[$];

  initial begin
    mismatch_count   = 0;
    subbands_pending = 0;
    errors           = 0;
  end

  function automatic longint saturate(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_pass;
    band_re    = 0;
    band_im    = 0;
    wide_re    = 0;
    wide_im    = 0;
    elem_count = 0;
    band_idx   = '0;
  endtask

  // One element: accumulate ch0 * conj(ch1) and close the subband when its
  // length is reached.
  task automatic correlate_element(
    input logic signed [scc_pkg::PORT_W-1:0] a_re,
    input logic signed [scc_pkg::PORT_W-1:0] a_im,
    input logic signed [scc_pkg::PORT_W-1:0] b_re,
    input logic signed [scc_pkg::PORT_W-1:0] b_im,
    input logic                              pass_start
  );
    logic          closing_band;
    int unsigned   band_len;
    longint        c_re;
    longint        c_im;
    subband_sums_t sums;
    if (pass_start) clear_pass();
    band_re += longint'(a_re) * longint'(b_re) + longint'(a_im) * longint'(b_im);
    band_im += longint'(a_im) * longint'(b_re) - longint'(a_re) * longint'(b_im);
    // Index 15 always closes the pass, whatever the subband count says.
    closing_band = (int'(band_idx) + 1 >= int'(band_count)) ||
                   (band_idx == scc_pkg::SB_IDX_MAX);
    band_len = closing_band ? 32'(last_len) : 32'(regular_len);
    if (elem_count + 1 < band_len) begin
      elem_count++;
    end else begin
      c_re    = saturate(band_re >>> 2, longint'(scc_pkg::CORR_MIN),
                         longint'(scc_pkg::CORR_MAX));
      c_im    = saturate(band_im >>> 2, longint'(scc_pkg::CORR_MIN),
                         longint'(scc_pkg::CORR_MAX));
      wide_re = saturate(wide_re + c_re, longint'(scc_pkg::WIDE_MIN),
                         longint'(scc_pkg::WIDE_MAX));
      wide_im = saturate(wide_im + c_im, longint'(scc_pkg::WIDE_MIN),
                         longint'(scc_pkg::WIDE_MAX));
      sums.index   = band_idx;
      sums.corr_re = c_re[scc_pkg::CORR_W-1:0];
      sums.corr_im = c_im[scc_pkg::CORR_W-1:0];
      sums.wide_re = wide_re[scc_pkg::WIDE_W-1:0];
      sums.wide_im = wide_im[scc_pkg::WIDE_W-1:0];
      sums.closing = closing_band;
      due_subbands.push_back(sums);
      band_re    = 0;
      band_im    = 0;
      elem_count = 0;
      band_idx   = closing_band ? '0 : band_idx + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input longint expected_v,
                             input longint actual_v);
    if (expected_v != actual_v) begin
      $error("%s: expected %0d, got %0d", name, expected_v, actual_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    subband_sums_t sums;
    if (!rst_n) begin
      regular_len = scc_pkg::REGULAR_RES_RST;
      last_len    = scc_pkg::LAST_RES_RST;
      band_count  = scc_pkg::SB_COUNT_RST;
      clear_pass();
      due_subbands.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          scc_pkg::CFG_REGULAR_RES: regular_len = cfg_wdata;
          scc_pkg::CFG_LAST_RES:    last_len    = cfg_wdata;
          scc_pkg::CFG_SB_COUNT:    band_count  = cfg_wdata[scc_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        correlate_element(in_ch0_re, in_ch0_im, in_ch1_re, in_ch1_im, in_pass_start);
      end
      if (out_valid && !out_stall) begin
        if (due_subbands.size() == 0) begin
          $error("result beat for subband %0d with no subband due", out_subband_index);
          errors++;
        end else begin
          sums = due_subbands.pop_front();
          check_field("subband_index", longint'(sums.index),
                      longint'(out_subband_index));
          check_field("corr_re", longint'(sums.corr_re), longint'(out_corr_re));
          check_field("corr_im", longint'(sums.corr_im), longint'(out_corr_im));
          check_field("wideband_re", longint'(sums.wide_re), longint'(out_wideband_re));
          check_field("wideband_im", longint'(sums.wide_im), longint'(out_wideband_im));
          check_field("last", longint'(sums.closing), longint'(out_last));
        end
      end
    end
    mismatch_count   <= errors;
    subbands_pending <= due_subbands.size();
  end

endmodule

@@ bench/subband_channel_correlator_test.sv @@
// ----------------------------------------------------------------------------
// subband_channel_correlator_test
// Stimulus and verdict for the subband channel correlator.
// ----------------------------------------------------------------------------
// A short directed run covers extreme samples, subbands of length zero and
// one, a zero subband count, counts above sixteen and a length change in the
// middle of a subband. Two long runs of extreme products then drive the
// subband and wideband sums into saturation, and random runs follow under
// random register settings. Both channels idle at random. The receiver also
// holds off for a long stretch once, so that the input side backs up.
// Registers are only written once every due subband has come out.
// ----------------------------------------------------------------------------
module subband_channel_correlator_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ELEMENTS = 1100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_START      = 300;
  localparam int HOLD_CYCLES     = 250;
  localparam int RX_STEADY_START = 1200;
  localparam int RX_STEADY_END   = 1600;
  localparam int TX_STEADY_START = 300;
  localparam int TX_STEADY_END   = 500;

  localparam logic signed [scc_pkg::PORT_W-1:0] MOST_NEG = 16'sh8000;
  localparam logic signed [scc_pkg::PORT_W-1:0] MOST_POS = 16'sh7FFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              cfg_we = 1'b0;
  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_index = scc_pkg::CFG_REGULAR_RES;
  logic [scc_pkg::RES_W-1:0]         cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [scc_pkg::PORT_W-1:0] in_ch0_re = '0;
  logic signed [scc_pkg::PORT_W-1:0] in_ch0_im = '0;
  logic signed [scc_pkg::PORT_W-1:0] in_ch1_re = '0;
  logic signed [scc_pkg::PORT_W-1:0] in_ch1_im = '0;
  logic                              in_pass_start = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [scc_pkg::IDX_W-1:0]         out_subband_index;
  logic signed [scc_pkg::CORR_W-1:0] out_corr_re;
  logic signed [scc_pkg::CORR_W-1:0] out_corr_im;
  logic signed [scc_pkg::WIDE_W-1:0] out_wideband_re;
  logic signed [scc_pkg::WIDE_W-1:0] out_wideband_im;
  logic                              out_last;

  int mismatch_count;
  int subbands_pending;
  int elements_sent = 0;
  int random_elements = 0;
  int rx_cycle = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  subband_channel_correlator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ch0_re         (in_ch0_re),
    .in_ch0_im         (in_ch0_im),
    .in_ch1_re         (in_ch1_re),
    .in_ch1_im         (in_ch1_im),
    .in_pass_start     (in_pass_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_subband_index (out_subband_index),
    .out_corr_re       (out_corr_re),
    .out_corr_im       (out_corr_im),
    .out_wideband_re   (out_wideband_re),
    .out_wideband_im   (out_wideband_im),
    .out_last          (out_last)
  );

  scc_result_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ch0_re         (in_ch0_re),
    .in_ch0_im         (in_ch0_im),
    .in_ch1_re         (in_ch1_re),
    .in_ch1_im         (in_ch1_im),
    .in_pass_start     (in_pass_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_subband_index (out_subband_index),
    .out_corr_re       (out_corr_re),
    .out_corr_im       (out_corr_im),
    .out_wideband_re   (out_wideband_re),
    .out_wideband_im   (out_wideband_im),
    .out_last          (out_last),
    .mismatch_count    (mismatch_count),
    .subbands_pending  (subbands_pending)
  );

  // The receiver stalls at random, except for one long hold-off and one
  // stretch where it takes every beat.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
      out_stall <= 1'b1;
    end else if (rx_cycle >= RX_STEADY_START && rx_cycle < RX_STEADY_END) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("subband_channel_correlator: mismatch");
        $finish;
      end
    end
  end

  function automatic logic signed [scc_pkg::PORT_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return '1;
      default: return scc_pkg::PORT_W'($urandom);
    endcase
  endfunction

  function automatic logic [scc_pkg::RES_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return '0;
      1: return scc_pkg::RES_W'(1);
      2: return '1;
      3: return scc_pkg::RES_W'($urandom_range(4, 64));
      default: return scc_pkg::RES_W'($urandom_range(2, 10));
    endcase
  endfunction

  // The register keeps only the low bits; the upper write bits are random.
  function automatic logic [scc_pkg::RES_W-1:0] pick_count();
    logic [scc_pkg::RES_W-1:0] v;
    v[scc_pkg::RES_W-1:scc_pkg::CNT_W] =
      (scc_pkg::RES_W-scc_pkg::CNT_W)'($urandom_range(3));
    case ($urandom_range(7))
      0: v[scc_pkg::CNT_W-1:0] = '0;
      1: v[scc_pkg::CNT_W-1:0] = scc_pkg::CNT_W'(16);
      2: v[scc_pkg::CNT_W-1:0] = scc_pkg::CNT_W'($urandom_range(17, 31));
      default: v[scc_pkg::CNT_W-1:0] = scc_pkg::CNT_W'($urandom_range(1, 6));
    endcase
    return v;
  endfunction

  task automatic send_element(
    input logic signed [scc_pkg::PORT_W-1:0] a_re,
    input logic signed [scc_pkg::PORT_W-1:0] a_im,
    input logic signed [scc_pkg::PORT_W-1:0] b_re,
    input logic signed [scc_pkg::PORT_W-1:0] b_im,
    input logic                              pass_start
  );
    if (elements_sent < TX_STEADY_START || elements_sent >= TX_STEADY_END) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_ch0_re     <= a_re;
    in_ch0_im     <= a_im;
    in_ch1_re     <= b_re;
    in_ch1_im     <= b_im;
    in_pass_start <= pass_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    elements_sent++;
  endtask

  // Elements that close no subband may still sit in the pipeline when the
  // last due subband comes out, hence the extra settle cycles.
  task automatic wait_idle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (subbands_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [scc_pkg::RES_W-1:0] regular_len,
                              input logic [scc_pkg::RES_W-1:0] last_len,
                              input logic [scc_pkg::RES_W-1:0] band_count);
    cfg_we    <= 1'b1;
    cfg_index <= scc_pkg::CFG_REGULAR_RES;
    cfg_wdata <= regular_len;
    @(posedge clk);
    cfg_index <= scc_pkg::CFG_LAST_RES;
    cfg_wdata <= last_len;
    @(posedge clk);
    cfg_index <= scc_pkg::CFG_SB_COUNT;
    cfg_wdata <= band_count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [scc_pkg::PORT_W-1:0] extremes [4];
    int                                n;
    extremes[0] = MOST_NEG;
    extremes[1] = MOST_POS;
    extremes[2] = '0;
    extremes[3] = '1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two elements under the default sizes leave subband 0 partly filled; the
    // new length of one then closes it on the next element.
    send_element(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 1'b0);
    send_element(MOST_POS, MOST_NEG, MOST_NEG, MOST_POS, 1'b0);
    wait_idle();
    write_config(scc_pkg::RES_W'(1), '0, scc_pkg::RES_W'(31));
    // Sixteen one-element subbands run up to index 15, which closes the pass
    // with a last subband of length zero.
    for (int k = 0; k < 17; k++) begin
      send_element(extremes[2'(k)], extremes[2'(k / 4)], extremes[2'(k + 1)],
                   extremes[2'(k / 2)], 1'b0);
    end
    send_element(MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, 1'b1);
    wait_idle();
    // With a subband count of zero every subband is the last one.
    write_config(scc_pkg::RES_W'(1), '0, '0);
    for (int k = 0; k < 3; k++) begin
      send_element(extremes[2'(k)], extremes[2'(3 - k)], extremes[2'(k + 2)],
                   extremes[2'(k)], 1'b0);
    end

    // Nine full-scale subbands saturate the real subband sum each time and
    // finally the real wideband sum.
    wait_idle();
    write_config(scc_pkg::RES_W'(64), scc_pkg::RES_W'(64), scc_pkg::RES_W'(17));
    for (int k = 0; k < 9 * 64; k++) begin
      send_element(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, k == 0);
      random_elements++;
    end
    // Long subbands push the real sum to the negative limit, then the
    // imaginary sum to the positive one.
    wait_idle();
    write_config('1, '1, '0);
    for (int k = 0; k < 2 * 127; k++) begin
      if (k < 127) begin
        send_element(MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, 1'b0);
      end else begin
        send_element(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, 1'b0);
      end
      random_elements++;
    end

    while (random_elements < RANDOM_ELEMENTS) begin
      wait_idle();
      write_config(pick_length(), pick_length(), pick_count());
      n = $urandom_range(8, 80);
      for (int k = 0; k < n; k++) begin
        send_element(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                     (k == 0) ? ($urandom_range(3) == 0) : ($urandom_range(49) == 0));
        random_elements++;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("subband_channel_correlator: match");
    end else begin
      $display("subband_channel_correlator: mismatch");
    end
    $finish;
  end

endmodule
